/* rtl/core/assert_macros.svh */
// assertion macros for the rtl modules; only ble_dpath includes them
// every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ble_pkg.sv */
// shared constants, types and index helpers for the bounded list engine
// no dependencies; ble_ctrl, ble_dpath and the top level refer to it by scoped names
package ble_pkg;

    // list sizing
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_KEY    = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS    = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_POS   = 3'd6;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic              capture;
        logic              push_back;
        logic              push_front;
        logic              pop_front;
        logic              shrink;
        logic              walk_key;
        logic              walk_pos;
        logic              walk_run;
        logic              rd_issue;
        logic              rd_capture;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            pos_ok;
        logic            walk_done;
        logic            hit;
        logic            out_free;
    } dp_stat_t;

    // circular index add, both operands below CAPACITY
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(CAPACITY))
        begin
            s = s - (IDX_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    // circular index decrement
    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0)
        begin
            r = IDX_W'(CAPACITY - 1);
        end
        else
        begin
            r = a - 1'b1;
        end
        return r;
    endfunction

    // circular index increment
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == IDX_W'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/core/ble_ram.sv */
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module ble_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ble_ctrl.sv */
// controller state machine for the bounded list engine
// depends on ble_pkg for opcodes, status codes and command/status structs
module ble_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ble_pkg::dp_stat_t stat,
    output ble_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                unique case (stat.op)
                    ble_pkg::OP_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_back = 1'b1;
                        end
                    end
                    ble_pkg::OP_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_front = 1'b1;
                        end
                    end
                    ble_pkg::OP_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_front = 1'b1;
                        end
                    end
                    ble_pkg::OP_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.shrink = 1'b1;
                        end
                    end
                    ble_pkg::OP_DEL_KEY:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.walk_key = 1'b1;
                            state_next   = S_WALK;
                        end
                    end
                    ble_pkg::OP_DEL_POS:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_EMPTY;
                        end
                        else if (!stat.pos_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.walk_pos = 1'b1;
                            state_next   = S_WALK;
                        end
                    end
                    ble_pkg::OP_READ_POS:
                    begin
                        if (!stat.pos_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ble_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_RDWAIT;
                        end
                    end
                    default:
                    begin
                        // undefined opcode: no change, ok status
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_FINISH;
            end
            S_WALK:
            begin
                cmd.walk_run = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_FINISH;
                    if (stat.hit)
                    begin
                        cmd.shrink = 1'b1;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ble_pkg::ST_NOTFOUND;
                    end
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ble_dpath.sv */
// datapath: circular entry store, compaction walk, result and output registers
// depends on ble_pkg, ble_ram and assert_macros.svh
`include "assert_macros.svh"

module ble_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ble_pkg::dp_cmd_t                    cmd,
    output ble_pkg::dp_stat_t                   stat,
    input  logic [ble_pkg::OP_W-1:0]            opcode,
    input  logic signed [ble_pkg::DATA_W-1:0]   item_value,
    input  logic [ble_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ble_pkg::STAT_W-1:0]          status,
    output logic signed [ble_pkg::DATA_W-1:0]   read_value,
    output logic [ble_pkg::LEN_W-1:0]           list_length
);

    // capacity as a count value
    localparam logic [ble_pkg::CNT_W-1:0] CAP_CNT = ble_pkg::CNT_W'(ble_pkg::CAPACITY);

    // control state
    logic [ble_pkg::IDX_W-1:0] head_reg,   head_next;
    logic [ble_pkg::CNT_W-1:0] count_reg,  count_next;
    logic [ble_pkg::CNT_W-1:0] ridx_reg,   ridx_next;
    logic [ble_pkg::CNT_W-1:0] didx_reg,   didx_next;
    logic                      dvalid_reg, dvalid_next;
    logic                      hit_reg,    hit_next;
    logic                      out_valid_reg, out_valid_next;

    // payload registers
    logic [ble_pkg::OP_W-1:0]   op_reg;
    logic [ble_pkg::DATA_W-1:0] val_reg;
    logic [ble_pkg::POS_W-1:0]  pos_reg;
    logic [ble_pkg::STAT_W-1:0] res_status_reg;
    logic [ble_pkg::DATA_W-1:0] res_data_reg;
    logic [ble_pkg::STAT_W-1:0] out_status_reg;
    logic [ble_pkg::DATA_W-1:0] out_data_reg;
    logic [ble_pkg::LEN_W-1:0]  out_len_reg;

    // ram port signals
    logic                       ram_we;
    logic [ble_pkg::IDX_W-1:0]  ram_waddr;
    logic [ble_pkg::DATA_W-1:0] ram_wdata;
    logic [ble_pkg::IDX_W-1:0]  ram_raddr;
    logic [ble_pkg::DATA_W-1:0] ram_rdata;

    logic                       issue;
    logic                       is_full;
    logic                       is_empty;
    logic [ble_pkg::POS_W-1:0]  pos_m1;
    logic [ble_pkg::CNT_W-1:0]  didx_m1;

    ble_ram #(
        .WIDTH (ble_pkg::DATA_W),
        .DEPTH (ble_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // list status
    assign is_full  = (count_reg == ble_pkg::CNT_W'(ble_pkg::CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_m1   = pos_reg - 1'b1;
    assign didx_m1  = didx_reg - 1'b1;
    assign issue    = cmd.walk_run && (ridx_reg < count_reg);

    assign stat.op        = op_reg;
    assign stat.full      = is_full;
    assign stat.empty     = is_empty;
    assign stat.pos_ok    = (pos_reg != '0) &&
                            (ble_pkg::CMP_W'(pos_reg) <= ble_pkg::CMP_W'(count_reg));
    assign stat.walk_done = (ridx_reg == count_reg) && !dvalid_reg;
    assign stat.hit       = hit_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // read address: walk cursor or requested position
    always_comb
    begin
        if (cmd.walk_run)
        begin
            ram_raddr = ble_pkg::wrap_add(head_reg, ridx_reg[ble_pkg::IDX_W-1:0]);
        end
        else
        begin
            ram_raddr = ble_pkg::wrap_add(head_reg, pos_m1[ble_pkg::IDX_W-1:0]);
        end
    end

    // write port: pushes and compaction moves
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ble_pkg::wrap_add(head_reg, count_reg[ble_pkg::IDX_W-1:0]);
        ram_wdata = val_reg;
        priority if (cmd.push_back)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.push_front)
        begin
            ram_we    = 1'b1;
            ram_waddr = ble_pkg::wrap_dec(head_reg);
        end
        else if (cmd.walk_run && dvalid_reg && hit_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = ble_pkg::wrap_add(head_reg, didx_m1[ble_pkg::IDX_W-1:0]);
            ram_wdata = ram_rdata;
        end
    end

    // head, count and walk next state
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        ridx_next   = ridx_reg;
        didx_next   = didx_reg;
        dvalid_next = 1'b0;
        hit_next    = hit_reg;
        if (cmd.push_back)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.push_front)
        begin
            head_next  = ble_pkg::wrap_dec(head_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop_front)
        begin
            head_next  = ble_pkg::wrap_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.shrink)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.walk_key)
        begin
            ridx_next = '0;
            hit_next  = 1'b0;
        end
        if (cmd.walk_pos)
        begin
            ridx_next = ble_pkg::CNT_W'(pos_reg);
            hit_next  = 1'b1;
        end
        if (cmd.walk_run)
        begin
            dvalid_next = issue;
            didx_next   = ridx_reg;
            if (issue)
            begin
                ridx_next = ridx_reg + 1'b1;
            end
            if (dvalid_reg && !hit_reg && (ram_rdata == val_reg))
            begin
                hit_next = 1'b1;
            end
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            ridx_reg      <= '0;
            didx_reg      <= '0;
            dvalid_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            ridx_reg      <= ridx_next;
            didx_reg      <= didx_next;
            dvalid_reg    <= dvalid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request, result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg         <= opcode;
            val_reg        <= item_value;
            pos_reg        <= position;
            res_status_reg <= ble_pkg::ST_OK;
            res_data_reg   <= '0;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.rd_capture)
        begin
            res_data_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_len_reg    <= ble_pkg::LEN_W'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign read_value  = out_data_reg;
    assign list_length = out_len_reg;

    // checks
    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CAP_CNT, "count over capacity")
    `ASSERT_IMPL(a_push_room, cmd.push_back || cmd.push_front, !is_full, "push into full list")
    `ASSERT_IMPL(a_pop_nonempty, cmd.pop_front || cmd.shrink, !is_empty, "remove from empty list")
    `ASSERT_NEXT(a_read_capture, cmd.rd_issue, cmd.rd_capture, "read issued but not captured")

endmodule

/* rtl/core/bounded_list_engine.sv */
// top level of the bounded list engine: controller plus datapath
// depends on ble_pkg, ble_ctrl and ble_dpath
//
// usage
//   request channel: opcode, item_value, position with in_valid / in_stall.
//   a request is taken when in_valid is high and in_stall is low.
//   result channel: status, read_value, list_length with out_valid / out_stall.
//   every request gives exactly one result, in request order.
// processing
//   push, pop, undefined opcode: EXEC works it, FINISH loads the result when
//   the output is free; read position: EXEC issues the read, RDWAIT captures
//   it, then FINISH; delete key or position: EXEC, the one-entry-per-cycle
//   compaction walk in WALK via the store's single read port, then FINISH.
//   the next request is taken the cycle after the result is registered.
// reset
//   rst_n clears the list to empty; store contents stay undefined.
// back-pressure
//   a held result stays stable under out_stall; the block may take and
//   work one more request meanwhile and then holds it until the output frees.
module bounded_list_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ble_pkg::OP_W-1:0]            opcode,
    input  logic signed [ble_pkg::DATA_W-1:0]   item_value,
    input  logic [ble_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ble_pkg::STAT_W-1:0]          status,
    output logic signed [ble_pkg::DATA_W-1:0]   read_value,
    output logic [ble_pkg::LEN_W-1:0]           list_length
);

    ble_pkg::dp_cmd_t  cmd;
    ble_pkg::dp_stat_t stat;

    ble_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ble_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .item_value  (item_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .list_length (list_length)
    );

endmodule
